// ===== hw/rtl/md5_pkg.sv =====
// Shared types and constants for the MD5 stream hasher.
`timescale 1ns / 1ps
package md5_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Command word passed from the front end to the round engine.
	typedef enum logic [1:0] {
		CMD_BYTE = 2'b01,
		CMD_END  = 2'b10
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	// Per-round additive constant.
	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		begin
			case (i)
				6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
				6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
				6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
				6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
				6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
				6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
				6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
				6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
				6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
				6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
				6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
				6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
				6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
				6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
				6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
				6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
				6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
				6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
				6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
				6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
				6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
				default: k = 32'heb86d391;
			endcase
			return k;
		end
	endfunction

	// Per-round rotate amount.
	function automatic logic [4:0] round_s(input logic [5:0] i);
		logic [4:0] s;
		begin
			case ({i[5:4], i[1:0]})
				4'b0000: s = 5'd7;  4'b0001: s = 5'd12; 4'b0010: s = 5'd17; 4'b0011: s = 5'd22;
				4'b0100: s = 5'd5;  4'b0101: s = 5'd9;  4'b0110: s = 5'd14; 4'b0111: s = 5'd20;
				4'b1000: s = 5'd4;  4'b1001: s = 5'd11; 4'b1010: s = 5'd16; 4'b1011: s = 5'd23;
				4'b1100: s = 5'd6;  4'b1101: s = 5'd10; 4'b1110: s = 5'd15; default: s = 5'd21;
			endcase
			return s;
		end
	endfunction

endpackage

// ===== hw/rtl/md5_cmd_fifo.sv =====
// Short command queue between the input front end and the round engine.
`timescale 1ns / 1ps
module md5_cmd_fifo
	import md5_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_cmd,
	output logic empty
);
	cmd_t       mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;

	assign full   = (cnt_q == 3'd4);
	assign empty  = (cnt_q == 3'd0);
	assign rd_cmd = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en && !full) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (rd_en && !empty) rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, wr_en && !full} - {2'b0, rd_en && !empty};
		end
	end
endmodule

// ===== hw/rtl/md5_engine.sv =====
// Back end: block buffer, padding sequencer, 64-round engine and digest output.
`timescale 1ns / 1ps
module md5_engine
	import md5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_empty,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_index,
	output logic [31:0] out_word,
	output logic        out_last
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_FETCH = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_ADD   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t      state_q;
	logic [31:0] buf_q [16];
	logic [60:0] count_q;
	logic [5:0]  pos_q;
	logic        final_q;
	logic        len_done_q;
	logic [5:0]  rnd_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] ha_q, hb_q, hc_q, hd_q;
	logic [31:0] w_s1;
	logic [1:0]  idx_q;

	// Message word index for the round after the current one.
	logic [5:0] nxt_rnd;
	logic [3:0] g_idx;
	assign nxt_rnd = rnd_q + 6'd1;
	always_comb begin
		unique case (nxt_rnd[5:4])
			2'd0: g_idx = nxt_rnd[3:0];
			2'd1: g_idx = 4'(5 * nxt_rnd[3:0] + 1);
			2'd2: g_idx = 4'(3 * nxt_rnd[3:0] + 5);
			default: g_idx = 4'(7 * nxt_rnd[3:0]);
		endcase
	end

	// Round function.
	logic [31:0] f_val, sum_val, rot_val;
	logic [4:0]  sh;
	always_comb begin
		unique case (rnd_q[5:4])
			2'd0: f_val = (b_q & c_q) | (~b_q & d_q);
			2'd1: f_val = (d_q & b_q) | (~d_q & c_q);
			2'd2: f_val = b_q ^ c_q ^ d_q;
			default: f_val = c_q ^ (b_q | ~d_q);
		endcase
		sh      = round_s(rnd_q);
		sum_val = a_q + f_val + round_k(rnd_q) + w_s1;
		rot_val = (sum_val << sh) | (sum_val >> (6'd32 - {1'b0, sh}));
	end

	// Padding byte for the current position.
	logic [63:0] bits;
	logic [7:0]  pad_byte;
	assign bits = {count_q, 3'b000};
	always_comb begin
		if (pos_q >= 6'd56 && len_done_q) pad_byte = bits[8*pos_q[2:0] +: 8];
		else pad_byte = 8'h00;
	end

	logic buf_we;
	logic [7:0] buf_wd;
	logic [5:0] buf_wa;
	logic [3:0] fetch_a;
	assign fetch_a = state_q == ST_FETCH ? 4'd0 : g_idx;

	assign cmd_pop   = (state_q == ST_IDLE) && !cmd_empty;
	assign out_valid = (state_q == ST_EMIT);
	assign out_index = idx_q;
	assign out_last  = (idx_q == 2'd3);
	always_comb begin
		case (idx_q)
			2'd0: out_word = ha_q;
			2'd1: out_word = hb_q;
			2'd2: out_word = hc_q;
			default: out_word = hd_q;
		endcase
	end

	// Buffer write control.
	always_comb begin
		buf_we = 1'b0;
		buf_wd = pad_byte;
		buf_wa = pos_q;
		if (cmd_pop) begin
			buf_we = 1'b1;
			buf_wd = (cmd.kind == CMD_BYTE) ? cmd.data : PAD_BYTE;
		end else if (state_q == ST_PAD) begin
			buf_we = 1'b1;
		end
	end

	// Block buffer of sixteen little-endian words: byte-lane writes, one registered word read.
	always_ff @(posedge clk) begin
		if (buf_we) buf_q[buf_wa[5:2]][{buf_wa[1:0], 3'b000} +: 8] <= buf_wd;
		w_s1 <= buf_q[fetch_a];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			pos_q      <= '0;
			final_q    <= 1'b0;
			len_done_q <= 1'b0;
			rnd_q      <= '0;
			idx_q      <= '0;
			ha_q <= IV_A; hb_q <= IV_B; hc_q <= IV_C; hd_q <= IV_D;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						pos_q <= pos_q + 6'd1;
						if (cmd.kind == CMD_BYTE) begin
							count_q <= count_q + 61'd1;
							if (pos_q == 6'd63) state_q <= ST_FETCH;
						end else begin
							final_q    <= 1'b1;
							len_done_q <= (pos_q < 6'd56);
							state_q    <= (pos_q == 6'd63) ? ST_FETCH : ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pos_q <= pos_q + 6'd1;
					if (pos_q == 6'd63) state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					rnd_q <= '0;
					a_q <= ha_q; b_q <= hb_q; c_q <= hc_q; d_q <= hd_q;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					a_q <= d_q; d_q <= c_q; c_q <= b_q;
					b_q <= b_q + rot_val;
					rnd_q <= nxt_rnd;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					ha_q <= ha_q + a_q; hb_q <= hb_q + b_q;
					hc_q <= hc_q + c_q; hd_q <= hd_q + d_q;
					if (!final_q) state_q <= ST_IDLE;
					else if (!len_done_q) begin
						len_done_q <= 1'b1;
						state_q    <= ST_PAD;
					end else begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							ha_q <= IV_A; hb_q <= IV_B; hc_q <= IV_C; hd_q <= IV_D;
							count_q <= '0;
							pos_q   <= '0;
							final_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/md5_stream_hasher_core.sv =====
// Top level of the streaming MD5 hasher: input front end, queue and round engine.
`timescale 1ns / 1ps
// Takes message bytes (tuser = 0) and an end marker (tuser = 1) and returns the four MD5
// digest words A, B, C, D, with tlast on D. The engine writes each byte into its block buffer;
// each full 64-byte block is then compressed in the single shared round unit (one round per
// cycle), and no byte is popped meanwhile. The end marker costs the padding fill, one or two
// block compressions and four output words. A four-word queue decouples input from the engine.
module md5_stream_hasher_core
	import md5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [1:0] word_index, [33:2] digest_word, [39:34] zero
	output logic        m_tlast   // last_word
);
	cmd_t       in_cmd, q_cmd;
	logic       q_full, q_empty, q_pop;
	logic [1:0] o_idx;
	logic [31:0] o_word;

	// Classify incoming words into commands.
	assign in_cmd.kind = s_tuser ? CMD_END : CMD_BYTE;
	assign in_cmd.data = s_tdata;
	assign s_tready    = !q_full;

	md5_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_en(s_tvalid), .wr_cmd(in_cmd), .full(q_full),
		.rd_en(q_pop), .rd_cmd(q_cmd), .empty(q_empty)
	);

	md5_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.cmd_empty(q_empty), .cmd(q_cmd), .cmd_pop(q_pop),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_index(o_idx), .out_word(o_word), .out_last(m_tlast)
	);

	assign m_tdata = {6'd0, o_word, o_idx};

	// The engine never pops an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("pop from empty command queue");
	// No command is popped while a digest word is being output.
	assert property (@(posedge clk) disable iff (!arst_n) m_tvalid |-> !q_pop)
		else $error("command taken during digest output");
	// The last word carries index three.
	assert property (@(posedge clk) disable iff (!arst_n) m_tlast |-> m_tdata[1:0] == 2'd3)
		else $error("last flag on wrong word");
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the streaming MD5 hasher core.
`timescale 1ns / 1ps
module testbench;
	import md5_pkg::*;

	localparam int DRAIN_CYCLES = 400;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [1:0]  word_index;
		logic [31:0] digest_word;
		logic        last_word;
	} digest_word_t;

	// One directed row: an input word and, where known at a glance, the digest it closes.
	typedef struct {
		logic        kind;
		logic [7:0]  data_byte;
		logic        has_digest;
		logic [31:0] digest [4];
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;

	// Predictor state.
	logic [31:0] hash_chain [4];
	logic [7:0]  msg_block [64];
	logic [60:0] msg_bytes;

	digest_word_t digest_queue [$];
	int errors;
	int stall_cycles;
	int digests_seen;
	int words_sent;

	md5_stream_hasher_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] rotl32(logic [31:0] v, int amt);
		return (v << amt) | (v >> (32 - amt));
	endfunction

	// Runs the 64 rounds over the current block into the chaining words.
	task automatic md5_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t;
		int g;
		int rot [16];
		logic [31:0] kc;
		rot = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
		a = hash_chain[0];
		b = hash_chain[1];
		c = hash_chain[2];
		d = hash_chain[3];
		for (int i = 0; i < 64; i++) begin
			kc = round_k(6'(i));
			if (i < 16) begin
				f = (b & c) | (~b & d);
				g = i;
			end else if (i < 32) begin
				f = (d & b) | (~d & c);
				g = (5 * i + 1) % 16;
			end else if (i < 48) begin
				f = b ^ c ^ d;
				g = (3 * i + 5) % 16;
			end else begin
				f = c ^ (b | ~d);
				g = (7 * i) % 16;
			end
			t = d;
			d = c;
			c = b;
			b = b + rotl32(a + f + kc + w[g], rot[(i / 16) * 4 + (i % 4)]);
			a = t;
		end
		hash_chain[0] += a;
		hash_chain[1] += b;
		hash_chain[2] += c;
		hash_chain[3] += d;
	endtask

	task automatic hash_restart();
		hash_chain = '{IV_A, IV_B, IV_C, IV_D};
		msg_bytes = '0;
	endtask

	// Applies one accepted input word; an end marker queues four digest words.
	task automatic hash_accept(logic kind, logic [7:0] data_byte);
		int pos;
		logic [63:0] bit_len;
		digest_word_t dw;
		pos = int'(msg_bytes[5:0]);
		if (!kind) begin
			msg_block[pos] = data_byte;
			msg_bytes = msg_bytes + 61'd1;
			if (msg_bytes[5:0] == 6'd0)
				md5_compress();
		end else begin
			bit_len = {msg_bytes, 3'b000};
			msg_block[pos] = PAD_BYTE;
			pos++;
			if (pos > 56) begin
				while (pos < 64)
					msg_block[pos++] = 8'h00;
				md5_compress();
				pos = 0;
			end
			while (pos < 56)
				msg_block[pos++] = 8'h00;
			for (int i = 0; i < 8; i++)
				msg_block[56+i] = bit_len[8*i +: 8];
			md5_compress();
			for (int i = 0; i < 4; i++) begin
				dw.word_index = 2'(i);
				dw.digest_word = hash_chain[i];
				dw.last_word = (i == 3);
				digest_queue = {digest_queue, dw};
			end
			hash_restart();
		end
	endtask

	// Sends one word with a random gap in front of it.
	task automatic send_word(logic kind, logic [7:0] data_byte);
		int gap;
		gap = $urandom_range(0, 3);
		if (($urandom_range(0, 9)) < 3)
			gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= data_byte;
		do @(posedge clk); while (!s_tready);
		hash_accept(kind, data_byte);
		words_sent++;
	endtask

	// Checks every accepted digest word against the oldest expectation.
	always @(posedge clk) begin
		digest_word_t exp_w;
		if (arst_n && m_tvalid && m_tready) begin
			if (digest_queue.size() == 0) begin
				$error("unexpected digest word %h", m_tdata);
				errors++;
			end else begin
				exp_w = digest_queue.pop_front();
				if (m_tdata[1:0] !== exp_w.word_index) begin
					$error("word_index expected %0d actual %0d", exp_w.word_index, m_tdata[1:0]);
					errors++;
				end
				if (m_tdata[33:2] !== exp_w.digest_word) begin
					$error("digest_word expected %h actual %h", exp_w.digest_word,
						m_tdata[33:2]);
					errors++;
				end
				if (m_tdata[39:34] !== 6'd0) begin
					$error("pad bits expected 0 actual %h", m_tdata[39:34]);
					errors++;
				end
				if (m_tlast !== exp_w.last_word) begin
					$error("last_word expected %0b actual %0b", exp_w.last_word, m_tlast);
					errors++;
				end
				if (exp_w.last_word)
					digests_seen++;
			end
		end
	end

	// Receiver backpressure: a random stall before each word, often none.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
			m_tready <= 1'b0;
			repeat (stall) @(posedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		stim_row_t rows [$];
		stim_row_t r;
		int msg_len;
		int lens [6];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = 1'b0;
		errors = 0;
		stall_cycles = 0;
		digests_seen = 0;
		words_sent = 0;
		hash_restart();
		for (int i = 0; i < 64; i++)
			msg_block[i] = 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty message, "abc", the bytes ff 00 80 7f, a second empty one.
		r.has_digest = 1'b1;
		r.kind = 1'b1;
		r.data_byte = 8'hff;
		r.digest = '{32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec};
		rows = {rows, r};
		r.has_digest = 1'b0;
		r.kind = 1'b0;
		r.data_byte = "a";
		rows = {rows, r};
		r.data_byte = "b";
		rows = {rows, r};
		r.data_byte = "c";
		rows = {rows, r};
		r.has_digest = 1'b1;
		r.kind = 1'b1;
		r.data_byte = 8'h00;
		r.digest = '{32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128};
		rows = {rows, r};
		r.has_digest = 1'b0;
		r.kind = 1'b0;
		r.data_byte = 8'hff;
		rows = {rows, r};
		r.data_byte = 8'h00;
		rows = {rows, r};
		r.data_byte = 8'h80;
		rows = {rows, r};
		r.data_byte = 8'h7f;
		rows = {rows, r};
		r.kind = 1'b1;
		r.data_byte = 8'h55;
		rows = {rows, r};
		r.has_digest = 1'b1;
		r.data_byte = 8'haa;
		r.digest = '{32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec};
		rows = {rows, r};

		foreach (rows[n]) begin
			send_word(rows[n].kind, rows[n].data_byte);
			if (rows[n].has_digest) begin
				for (int i = 0; i < 4; i++)
					if (digest_queue[digest_queue.size() - 4 + i].digest_word
						!== rows[n].digest[i]) begin
						$error("digest_word expected %h actual %h", rows[n].digest[i],
							digest_queue[digest_queue.size() - 4 + i].digest_word);
						errors++;
					end
			end
		end

		// Lengths around the padding boundaries, then mostly short random messages.
		lens = '{55, 56, 57, 63, 64, 65};
		foreach (lens[n]) begin
			for (int i = 0; i < lens[n]; i++)
				send_word(1'b0, 8'($urandom));
			send_word(1'b1, 8'($urandom));
		end
		while (words_sent < 400) begin
			msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70)
				: $urandom_range(0, 12);
			for (int i = 0; i < msg_len; i++)
				send_word(1'b0, 8'($urandom));
			send_word(1'b1, 8'($urandom));
		end
		s_tvalid <= 1'b0;

		while (digest_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d input words and checked %0d digests, including the", words_sent,
			digests_seen);
		$display("empty message and lengths around the one- and two-block padding limits.");
		if (errors == 0 && digest_queue.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/md5_pkg.sv
hw/rtl/md5_cmd_fifo.sv
hw/rtl/md5_engine.sv
hw/rtl/md5_stream_hasher_core.sv
tb/sv/testbench.sv
